// ===== design/trp_pkg.sv =====
// Shared types and constants for the telnet receive parser.
// Telnet byte codes, parser states, event codes and the result record.
// No dependencies; compile first.
package trp_pkg;

  typedef logic [7:0]  byte_t;
  typedef logic [15:0] word_t;

  // Default sizes handed to the top-level parameters
  localparam int LINE_CAPACITY_DEF   = 256;
  localparam int SUBNEG_CAPACITY_DEF = 64;

  // Telnet command bytes
  localparam byte_t B_IAC  = 8'hFF;
  localparam byte_t B_DONT = 8'hFE;
  localparam byte_t B_DO   = 8'hFD;
  localparam byte_t B_WONT = 8'hFC;
  localparam byte_t B_WILL = 8'hFB;
  localparam byte_t B_SB   = 8'hFA;
  localparam byte_t B_EL   = 8'hF8;
  localparam byte_t B_EC   = 8'hF7;
  localparam byte_t B_SE   = 8'hF0;
  localparam byte_t OPT_NAWS = 8'd31;

  // Line-editing bytes
  localparam byte_t B_BS       = 8'h08;
  localparam byte_t B_DEL      = 8'h7F;
  localparam byte_t B_LF       = 8'h0A;
  localparam byte_t B_PRINT_LO = 8'h20;
  localparam byte_t B_PRINT_HI = 8'h7E;

  // Window size subnegotiation payload length and reset window
  localparam int    NAWS_LEN     = 4;
  localparam word_t WIN_W_RESET  = 16'd80;
  localparam word_t WIN_H_RESET  = 16'd25;

  typedef enum logic [2:0] {
    ST_DATA   = 3'd0,
    ST_IAC    = 3'd1,
    ST_CMD    = 3'd2,
    ST_SB     = 3'd3,
    ST_SB_IAC = 3'd4,
    ST_CLOSED = 3'd5
  } parse_state_t;

  typedef enum logic [2:0] {
    EV_CHAR     = 3'd0,
    EV_ERASE    = 3'd1,
    EV_KILL     = 3'd2,
    EV_EOL      = 3'd3,
    EV_OVERFLOW = 3'd4,
    EV_NEG      = 3'd5,
    EV_WIN      = 3'd6
  } event_kind_t;

  // One step's outcome from the parser core to the output stage
  typedef struct packed {
    logic        valid;
    event_kind_t kind;
    byte_t       data;
    byte_t       len;
    byte_t       cmd;
    byte_t       opt;
    word_t       width;
    word_t       height;
  } trp_result_t;

endpackage

// ===== design/trp_in_if.sv =====
// Received-byte channel: valid/ready handshake with one byte of payload.
// Depends on nothing.
interface trp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

// ===== design/trp_out_if.sv =====
// Parser event channel: valid/ready handshake with one line-editing event.
// Depends on nothing.
interface trp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_kind;
  logic [7:0]  data_byte;
  logic [7:0]  line_length;
  logic [7:0]  neg_command;
  logic [7:0]  neg_option;
  logic [15:0] win_width;
  logic [15:0] win_height;

  modport source (output valid, output event_kind, output data_byte, output line_length,
                  output neg_command, output neg_option, output win_width,
                  output win_height, input ready);
  modport sink   (input valid, input event_kind, input data_byte, input line_length,
                  input neg_command, input neg_option, input win_width,
                  input win_height, output ready);
endinterface

// ===== design/telnet_receive_parser_unit.sv =====
// Telnet receive parser: byte input register, parser core, event register.
// Top level; depends on trp_pkg, trp_in_if, trp_out_if, trp_parser_core
// and trp_out_stage.
//
// Usage:
//   in_chan carries one received byte per transfer. The parser strips
//   telnet IAC sequences and reports line-editing events on out_chan:
//   accepted character, erase char, erase line, line end with its length,
//   overflow, option negotiation and NAWS window size updates.
//   Bytes that produce no event (IAC prefixes, control bytes, sub-
//   negotiation payload, anything after overflow) are consumed silently.
// Path: a byte transfers into the input register, then its event is loaded
//   into the event register and offered on out_chan.
// Throughput: one byte per cycle while out_chan is not stalled. The whole
//   per-byte state update is compare and increment logic in the parser core.
// Stall: when out_chan holds an undelivered event and ready is low, the
//   byte in the input register waits and in_chan.ready drops; a byte that
//   yields no event still waits for the slot to free. Nothing is dropped.
// Reset (rst_n low, synchronous): parser back in data state, line empty,
//   window 80 x 25, both registers empty. Overflow stays closed until reset.
module telnet_receive_parser_unit #(
  parameter int LINE_CAPACITY   = trp_pkg::LINE_CAPACITY_DEF,
  parameter int SUBNEG_CAPACITY = trp_pkg::SUBNEG_CAPACITY_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  trp_in_if.sink    in_chan,
  trp_out_if.source out_chan
);

  logic                 in_valid_r;
  trp_pkg::byte_t       in_byte_r;
  logic                 slot_free;
  logic                 advance;
  logic                 in_xfer;
  trp_pkg::trp_result_t res;

  // Advance the held byte into the core whenever the event slot can take it
  assign advance        = in_valid_r && slot_free;
  assign in_chan.ready  = !in_valid_r || slot_free;
  assign in_xfer        = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_xfer) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  // Hold the byte until the core consumes it
  always_ff @(posedge clk) begin
    if (in_xfer) in_byte_r <= in_chan.in_byte;
  end

  trp_parser_core #(
    .LINE_CAPACITY   (LINE_CAPACITY),
    .SUBNEG_CAPACITY (SUBNEG_CAPACITY)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .rx_byte (in_byte_r),
    .res     (res)
  );

  trp_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance),
    .res       (res),
    .slot_free (slot_free),
    .out_chan  (out_chan)
  );

endmodule

// ===== design/trp_parser_core.sv =====
// Telnet parser state and per-byte decode: one byte consumed per step.
// Depends on trp_pkg.
module trp_parser_core #(
  parameter int LINE_CAPACITY   = trp_pkg::LINE_CAPACITY_DEF,
  parameter int SUBNEG_CAPACITY = trp_pkg::SUBNEG_CAPACITY_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  trp_pkg::byte_t      rx_byte,
  output trp_pkg::trp_result_t res
);

  localparam int LcW = $clog2(LINE_CAPACITY);
  localparam int ScW = $clog2(SUBNEG_CAPACITY + 1);
  localparam logic [LcW-1:0] LineLast  = LcW'(LINE_CAPACITY - 1);
  localparam logic [ScW-1:0] SubnegMax = ScW'(SUBNEG_CAPACITY);
  localparam logic [ScW-1:0] NawsLen   = ScW'(trp_pkg::NAWS_LEN);

  trp_pkg::parse_state_t state_r, state_nxt;
  trp_pkg::byte_t        pend_cmd_r, pend_cmd_nxt;
  trp_pkg::byte_t        pend_opt_r, pend_opt_nxt;
  trp_pkg::byte_t        sb_bytes_r [trp_pkg::NAWS_LEN];
  logic [ScW-1:0]        sb_cnt_r, sb_cnt_nxt;
  logic [LcW-1:0]        line_cnt_r, line_cnt_nxt;
  trp_pkg::word_t        win_w_r, win_w_nxt;
  trp_pkg::word_t        win_h_r, win_h_nxt;

  logic is_erase, is_lf, is_cmd, is_print, line_full, collect_en;
  logic [LcW-1:0] cnt_dec;

  assign is_erase  = (rx_byte == trp_pkg::B_BS) || (rx_byte == trp_pkg::B_DEL);
  assign is_lf     = (rx_byte == trp_pkg::B_LF);
  assign is_cmd    = (rx_byte == trp_pkg::B_DO) || (rx_byte == trp_pkg::B_DONT) ||
                     (rx_byte == trp_pkg::B_SB) || (rx_byte == trp_pkg::B_WILL) ||
                     (rx_byte == trp_pkg::B_WONT);
  assign is_print  = (rx_byte >= trp_pkg::B_PRINT_LO) && (rx_byte <= trp_pkg::B_PRINT_HI);
  assign line_full = (line_cnt_r >= LineLast);
  assign cnt_dec   = (line_cnt_r != '0) ? line_cnt_r - LcW'(1) : line_cnt_r;

  // Next parser state
  always_comb begin
    state_nxt = state_r;
    if (step) begin
      unique case (state_r)
        trp_pkg::ST_DATA: begin
          if (rx_byte == trp_pkg::B_IAC) state_nxt = trp_pkg::ST_IAC;
          else if (!is_erase && !is_lf && line_full) state_nxt = trp_pkg::ST_CLOSED;
        end
        trp_pkg::ST_IAC: begin
          if ((rx_byte == trp_pkg::B_EC) || (rx_byte == trp_pkg::B_EL))
            state_nxt = trp_pkg::ST_DATA;
          else if (is_cmd) state_nxt = trp_pkg::ST_CMD;
          else if ((rx_byte == trp_pkg::B_IAC) && line_full) state_nxt = trp_pkg::ST_CLOSED;
          else state_nxt = trp_pkg::ST_DATA;
        end
        trp_pkg::ST_CMD: begin
          state_nxt = (pend_cmd_r == trp_pkg::B_SB) ? trp_pkg::ST_SB : trp_pkg::ST_DATA;
        end
        trp_pkg::ST_SB: begin
          if (rx_byte == trp_pkg::B_IAC) state_nxt = trp_pkg::ST_SB_IAC;
        end
        trp_pkg::ST_SB_IAC: begin
          state_nxt = (rx_byte == trp_pkg::B_SE) ? trp_pkg::ST_DATA : trp_pkg::ST_SB;
        end
        trp_pkg::ST_CLOSED: state_nxt = trp_pkg::ST_CLOSED;
        default: state_nxt = trp_pkg::ST_DATA;
      endcase
    end
  end

  // Datapath updates and the event for this step
  always_comb begin
    pend_cmd_nxt = pend_cmd_r;
    pend_opt_nxt = pend_opt_r;
    sb_cnt_nxt   = sb_cnt_r;
    line_cnt_nxt = line_cnt_r;
    win_w_nxt    = win_w_r;
    win_h_nxt    = win_h_r;
    collect_en   = 1'b0;
    res          = '0;
    res.kind     = trp_pkg::EV_CHAR;
    res.len      = trp_pkg::byte_t'(line_cnt_r);
    if (step) begin
      unique case (state_r)
        trp_pkg::ST_DATA: begin
          if (rx_byte == trp_pkg::B_IAC) begin
            res.valid = 1'b0;
          end else if (is_erase) begin
            line_cnt_nxt = cnt_dec;
            res.valid    = 1'b1;
            res.kind     = trp_pkg::EV_ERASE;
            res.len      = trp_pkg::byte_t'(cnt_dec);
          end else if (is_lf) begin
            line_cnt_nxt = '0;
            res.valid    = 1'b1;
            res.kind     = trp_pkg::EV_EOL;
          end else if (line_full) begin
            res.valid = 1'b1;
            res.kind  = trp_pkg::EV_OVERFLOW;
          end else if (is_print) begin
            line_cnt_nxt = line_cnt_r + LcW'(1);
            res.valid    = 1'b1;
            res.data     = rx_byte;
            res.len      = trp_pkg::byte_t'(line_cnt_r + LcW'(1));
          end
        end
        trp_pkg::ST_IAC: begin
          if (rx_byte == trp_pkg::B_EC) begin
            line_cnt_nxt = cnt_dec;
            res.valid    = 1'b1;
            res.kind     = trp_pkg::EV_ERASE;
            res.len      = trp_pkg::byte_t'(cnt_dec);
          end else if (rx_byte == trp_pkg::B_EL) begin
            line_cnt_nxt = '0;
            res.valid    = 1'b1;
            res.kind     = trp_pkg::EV_KILL;
            res.len      = '0;
          end else if (is_cmd) begin
            pend_cmd_nxt = rx_byte;
          end else if (rx_byte == trp_pkg::B_IAC) begin
            // escaped 0xFF is a character like any other
            res.valid = 1'b1;
            if (line_full) begin
              res.kind = trp_pkg::EV_OVERFLOW;
            end else begin
              line_cnt_nxt = line_cnt_r + LcW'(1);
              res.data     = rx_byte;
              res.len      = trp_pkg::byte_t'(line_cnt_r + LcW'(1));
            end
          end
        end
        trp_pkg::ST_CMD: begin
          pend_opt_nxt = rx_byte;
          if (pend_cmd_r == trp_pkg::B_SB) begin
            sb_cnt_nxt = '0;
          end else begin
            res.valid = 1'b1;
            res.kind  = trp_pkg::EV_NEG;
            res.cmd   = pend_cmd_r;
            res.opt   = rx_byte;
          end
        end
        trp_pkg::ST_SB: begin
          collect_en = (rx_byte != trp_pkg::B_IAC);
        end
        trp_pkg::ST_SB_IAC: begin
          if (rx_byte == trp_pkg::B_SE) begin
            if ((pend_opt_r == trp_pkg::OPT_NAWS) && (sb_cnt_r == NawsLen)) begin
              win_w_nxt = {sb_bytes_r[0], sb_bytes_r[1]};
              win_h_nxt = {sb_bytes_r[2], sb_bytes_r[3]};
              res.valid = 1'b1;
              res.kind  = trp_pkg::EV_WIN;
            end
          end else begin
            collect_en = 1'b1;
          end
        end
        trp_pkg::ST_CLOSED: res.valid = 1'b0;
        default: res.valid = 1'b0;
      endcase
    end
    // count saturates at capacity; only the first four bytes are kept
    if (collect_en && (sb_cnt_r < SubnegMax)) sb_cnt_nxt = sb_cnt_r + ScW'(1);
    res.width  = win_w_nxt;
    res.height = win_h_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= trp_pkg::ST_DATA;
      pend_cmd_r <= '0;
      pend_opt_r <= '0;
      sb_cnt_r   <= '0;
      line_cnt_r <= '0;
      win_w_r    <= trp_pkg::WIN_W_RESET;
      win_h_r    <= trp_pkg::WIN_H_RESET;
    end else begin
      state_r    <= state_nxt;
      pend_cmd_r <= pend_cmd_nxt;
      pend_opt_r <= pend_opt_nxt;
      sb_cnt_r   <= sb_cnt_nxt;
      line_cnt_r <= line_cnt_nxt;
      win_w_r    <= win_w_nxt;
      win_h_r    <= win_h_nxt;
    end
  end

  // Subnegotiation payload bytes: written at the fill position
  always_ff @(posedge clk) begin
    if (collect_en && (sb_cnt_r < NawsLen)) sb_bytes_r[sb_cnt_r[1:0]] <= rx_byte;
  end

  a_closed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == trp_pkg::ST_CLOSED) |=> (state_r == trp_pkg::ST_CLOSED))
    else $error("closed state left without reset");

  a_overflow_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (res.valid && (res.kind == trp_pkg::EV_OVERFLOW)) |=> (state_r == trp_pkg::ST_CLOSED))
    else $error("overflow event did not close the parser");

  a_line_bound: assert property (@(posedge clk) disable iff (!rst_n)
    line_cnt_r <= LineLast)
    else $error("line count beyond capacity");

  a_subneg_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sb_cnt_r <= SubnegMax)
    else $error("subnegotiation count beyond capacity");

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !step |-> (!res.valid && (state_nxt == state_r) && (line_cnt_nxt == line_cnt_r)))
    else $error("parser changed without a byte");

endmodule

// ===== design/trp_out_stage.sv =====
// Result register for parser events, driving the event channel.
// Depends on trp_pkg and trp_out_if.
module trp_out_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  trp_pkg::trp_result_t res,
  output logic                 slot_free,
  trp_out_if.source            out_chan
);

  logic                 out_valid_r;
  trp_pkg::trp_result_t out_data_r;

  // The slot frees when empty or when the held event transfers this cycle
  assign slot_free = !out_valid_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load && res.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res.valid) out_data_r <= res;
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.event_kind  = out_data_r.kind;
  assign out_chan.data_byte   = out_data_r.data;
  assign out_chan.line_length = out_data_r.len;
  assign out_chan.neg_command = out_data_r.cmd;
  assign out_chan.neg_option  = out_data_r.opt;
  assign out_chan.win_width   = out_data_r.width;
  assign out_chan.win_height  = out_data_r.height;

endmodule
